// ----- hw/rtl/mexp_pkg.sv -----
// shared constants and register codes for the modular exponentiation block
package mexp_pkg;

    // default datapath width of modulus and base
    localparam int MOD_WIDTH_DEF = 32;

    // width of the stream data fields and of the configuration data
    localparam int FIELD_W = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

    // register reset values
    localparam logic [FIELD_W-1:0] EXPONENT_RESET = 32'd1;
    localparam logic [FIELD_W-1:0] MODULUS_RESET  = 32'hFFFF_FFFF;

endpackage

// ----- hw/rtl/mexp_mulmod.sv -----
// bit-serial modular multiplier, double-and-add with interleaved reduction
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MOD_WIDTH-1:0] a,
    input  logic [MOD_WIDTH-1:0] b,
    input  logic [MOD_WIDTH-1:0] m,
    output logic                 done,
    output logic [MOD_WIDTH-1:0] prod
);

    localparam int CNT_W = $clog2(MOD_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_WIDTH - 1);

    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] b_sh_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 phase_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [MOD_WIDTH-1:0] addend;
    logic [MOD_WIDTH:0]   sum;
    logic [MOD_WIDTH:0]   sum_red;
    logic [MOD_WIDTH-1:0] acc_next;
    logic                 do_add;

    // one modular add per cycle: double on phase 0, add a on phase 1 if the bit is set
    always_comb
    begin
        addend  = phase_reg ? a : acc_reg;
        sum     = {1'b0, acc_reg} + {1'b0, addend};
        sum_red = sum - {1'b0, m};
        if (sum >= {1'b0, m})
        begin
            acc_next = sum_red[MOD_WIDTH-1:0];
        end
        else
        begin
            acc_next = sum[MOD_WIDTH-1:0];
        end
        do_add = !phase_reg || b_sh_reg[MOD_WIDTH-1];
    end

    // sequencing of the multiplier bits, msb first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg   <= CNT_LAST;
                phase_reg <= 1'b0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    if (cnt_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
            end
        end
    end

    // accumulator and multiplier shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            b_sh_reg <= b;
        end
        else if (busy_reg)
        begin
            if (do_add)
            begin
                acc_reg <= acc_next;
            end
            if (phase_reg)
            begin
                b_sh_reg <= {b_sh_reg[MOD_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- hw/rtl/modular_exponentiation.sv -----
// modular exponentiation top level, right-to-left square-and-multiply
// usage:
//   configuration: cfg_we/cfg_index/cfg_data write the exponent (index 0) and
//   the modulus (index 1); write only while the block is idle.
//   input channel s_*: one item carries a base word in s_tdata and a last
//   marker in s_tlast; output channel m_* returns base^exponent mod modulus
//   with the marker copied to m_tlast.
// sequence from an accepted item to m_tvalid:
//   exponent zero or modulus below two: straight to the finish step.
//   otherwise the base is reduced first (one quotient bit per cycle), then
//   each exponent bit up to the highest set bit takes one pass of the two
//   bit-serial multipliers that square and multiply in parallel, then the
//   result is written to the output register once that register is free.
// throughput: one item at a time; a new item is accepted as soon as the
//   previous result sits in the output register, even while it is stalled.
// reset: exponent returns to 1, modulus to all ones, both channels empty.
// stall: a held result keeps m_tvalid and its data until m_tready is high;
//   a finished item waits for the output register to free.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [FIELD_W-1:0]   s_tdata,   // [31:0] base_value
    input  logic                 s_tlast,   // last_in
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [FIELD_W-1:0]   m_tdata,   // [31:0] power_result
    output logic                 m_tlast    // last_out
);

    localparam int CNT_W = $clog2(MOD_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_WIDTH - 1);
    localparam logic [MOD_WIDTH-1:0] ONE = MOD_WIDTH'(1);
    localparam logic [MOD_WIDTH-1:0] TWO = MOD_WIDTH'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MUL,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [FIELD_W-1:0]   exponent_reg;
    logic [FIELD_W-1:0]   modulus_reg;

    logic [MOD_WIDTH-1:0] m_reg;
    logic [MOD_WIDTH-1:0] base_reg;
    logic [MOD_WIDTH-1:0] rem_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [FIELD_W-1:0]   ex_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 last_reg;
    logic                 start_reg;

    logic                 out_valid_reg;
    logic [FIELD_W-1:0]   out_data_reg;
    logic                 out_last_reg;

    logic                 in_take;
    logic [MOD_WIDTH-1:0] in_base;
    logic [MOD_WIDTH-1:0] in_mod;
    logic [MOD_WIDTH:0]   trial;
    logic [MOD_WIDTH:0]   trial_sub;
    logic [MOD_WIDTH-1:0] rem_next;
    logic                 out_free;

    logic                 mul_done;
    logic                 sq_done;
    logic [MOD_WIDTH-1:0] mul_prod;
    logic [MOD_WIDTH-1:0] sq_prod;

    // handshake and input masking
    assign s_tready = (state_reg == S_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign in_base  = MOD_WIDTH'(s_tdata);
    assign in_mod   = MOD_WIDTH'(modulus_reg);
    assign out_free = !out_valid_reg || m_tready;

    // restoring division step for the base reduction
    always_comb
    begin
        trial     = {rem_reg, base_reg[MOD_WIDTH-1]};
        trial_sub = trial - {1'b0, m_reg};
        if (trial >= {1'b0, m_reg})
        begin
            rem_next = trial_sub[MOD_WIDTH-1:0];
        end
        else
        begin
            rem_next = trial[MOD_WIDTH-1:0];
        end
    end

    // multiply unit: acc * base
    mexp_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .a     (acc_reg),
        .b     (base_reg),
        .m     (m_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // square unit: base * base
    mexp_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .a     (base_reg),
        .b     (base_reg),
        .m     (m_reg),
        .done  (sq_done),
        .prod  (sq_prod)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= EXPONENT_RESET;
            modulus_reg  <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_data;
                REG_MODULUS:  modulus_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // sequencer with output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_reg         <= '0;
            base_reg      <= '0;
            rem_reg       <= '0;
            acc_reg       <= '0;
            ex_reg        <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        m_reg    <= in_mod;
                        base_reg <= in_base;
                        rem_reg  <= '0;
                        ex_reg   <= exponent_reg;
                        last_reg <= s_tlast;
                        cnt_reg  <= CNT_LAST;
                        priority if (exponent_reg == '0)
                        begin
                            acc_reg   <= ONE;
                            state_reg <= S_FINISH;
                        end
                        else if (in_mod < TWO)
                        begin
                            acc_reg   <= '0;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            acc_reg   <= ONE;
                            state_reg <= S_REDUCE;
                        end
                    end
                end

                S_REDUCE:
                begin
                    rem_reg  <= rem_next;
                    base_reg <= {base_reg[MOD_WIDTH-2:0], 1'b0};
                    if (cnt_reg == '0)
                    begin
                        base_reg  <= rem_next;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end

                S_MUL:
                begin
                    if (ex_reg == '0)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        start_reg <= 1'b1;
                        state_reg <= S_WAIT;
                    end
                end

                S_WAIT:
                begin
                    if (mul_done && sq_done)
                    begin
                        if (ex_reg[0])
                        begin
                            acc_reg <= mul_prod;
                        end
                        base_reg  <= sq_prod;
                        ex_reg    <= {1'b0, ex_reg[FIELD_W-1:1]};
                        state_reg <= S_MUL;
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= FIELD_W'(acc_reg);
                        out_last_reg  <= last_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- test/modular_exponentiation_tb.sv -----
// self-checking testbench for the modular exponentiation block
module modular_exponentiation_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    // cycle budget, several times the slowest correct run
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_KEYS = 10;
    localparam int WORDS_PER_KEY = 27;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [FIELD_W-1:0] power;
        logic               last;
    } power_item_t;

    // key copy, power predictor and queue of pending powers
    class power_scoreboard;
        logic [FIELD_W-1:0] key_exponent;
        logic [FIELD_W-1:0] key_modulus;
        power_item_t        expected_powers[$];
        int                 failures;

        function new();
            key_exponent = EXPONENT_RESET;
            key_modulus  = MODULUS_RESET;
            failures     = 0;
        endfunction

        function void set_key(logic [FIELD_W-1:0] ex, logic [FIELD_W-1:0] md);
            key_exponent = ex;
            key_modulus  = md;
        endfunction

        // right-to-left square-and-multiply on 64-bit products
        function logic [FIELD_W-1:0] power_mod(logic [FIELD_W-1:0] base);
            longint unsigned    acc;
            longint unsigned    sq;
            longint unsigned    md;
            logic [FIELD_W-1:0] ex;
            if (key_exponent == '0)
                return 1;
            if (key_modulus < 2)
                return 0;
            md  = key_modulus;
            sq  = base % md;
            acc = 1;
            ex  = key_exponent;
            while (ex != '0)
            begin
                if (ex[0])
                    acc = (acc * sq) % md;
                sq = (sq * sq) % md;
                ex = ex >> 1;
            end
            return acc[FIELD_W-1:0];
        endfunction

        function void note_word(logic [FIELD_W-1:0] base, logic last);
            power_item_t item;
            item.power = power_mod(base);
            item.last  = last;
            expected_powers.push_back(item);
        endfunction

        function void check_word(logic [FIELD_W-1:0] power, logic last);
            power_item_t item;
            if (expected_powers.size() == 0)
            begin
                $display("%0t: unexpected result %h last %b", $time, power, last);
                failures++;
                return;
            end
            item = expected_powers.pop_front();
            if (power !== item.power)
            begin
                $display("%0t: power mismatch, expected %h, actual %h",
                         $time, item.power, power);
                failures++;
            end
            if (last !== item.last)
            begin
                $display("%0t: last mismatch, expected %b, actual %b",
                         $time, item.last, last);
                failures++;
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_EXPONENT;
    logic [FIELD_W-1:0]   cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [FIELD_W-1:0]   s_tdata = '0;     // [31:0] base_value
    logic                 s_tlast = 1'b0;   // last_in
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [FIELD_W-1:0]   m_tdata;          // [31:0] power_result
    logic                 m_tlast;          // last_out

    power_scoreboard powers = new();
    int              cycle_count = 0;
    int              send_calm = 0;
    int              take_calm = 0;

    modular_exponentiation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // idle cycles before an item, with occasional stretches of none
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            calm = $urandom_range(4, 12);
        return $urandom_range(0, 16);
    endfunction

    // write both key registers once the block has drained
    task automatic set_key(input logic [FIELD_W-1:0] ex, input logic [FIELD_W-1:0] md);
        s_tvalid <= 1'b0;
        while (powers.pending() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_EXPONENT;
        cfg_data  <= ex;
        @(posedge clk);
        cfg_index <= REG_MODULUS;
        cfg_data  <= md;
        @(posedge clk);
        cfg_we <= 1'b0;
        powers.set_key(ex, md);
    endtask

    // offer one base word, optionally after the block has emptied
    task automatic send_word(input logic [FIELD_W-1:0] base, input logic last,
                             input bit pause);
        int gap;
        gap = draw_gap(send_calm);
        if (pause || gap > 0)
            s_tvalid <= 1'b0;
        if (pause)
        begin
            @(posedge clk);
            while (powers.pending() != 0)
                @(posedge clk);
        end
        repeat (gap) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= base;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        powers.note_word(base, last);
    endtask

    // result side with random stalls
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = draw_gap(take_calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            powers.check_word(m_tdata, m_tlast);
        end
    end

    // stimulus
    initial
    begin
        logic [FIELD_W-1:0] ex;
        logic [FIELD_W-1:0] md;
        logic [FIELD_W-1:0] b;
        int                 w;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key: exponent one, modulus all ones
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'h0000_0001, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h1234_5678, 1'b1, 1'b0);

        // zero exponent gives one
        set_key(32'd0, 32'd2);
        send_word(32'h0000_0000, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);

        // degenerate moduli
        set_key(32'd3, 32'd1);
        send_word(32'd7, 1'b1, 1'b0);
        set_key(32'd5, 32'd0);
        send_word(32'd9, 1'b0, 1'b0);
        set_key(32'd0, 32'd0);
        send_word(32'd3, 1'b1, 1'b0);

        // full-width exponent and modulus, base equal to modulus
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h0000_0002, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);

        // smallest modulus
        set_key(32'd65537, 32'd2);
        send_word(32'd3, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);

        // base just below, at and above the modulus
        set_key(32'd65537, 32'hFFFF_FFFB);
        send_word(32'hFFFF_FFFA, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFB, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFC, 1'b0, 1'b0);

        // random keys, mostly short exponents
        for (int k = 0; k < RANDOM_KEYS; k++)
        begin
            case ($urandom_range(0, 9))
                0:       ex = $urandom() | 32'h8000_0000;
                1:       ex = 32'd65537;
                2:       ex = $urandom_range(0, 1);
                default:
                begin
                    w  = $urandom_range(2, 12);
                    ex = $urandom_range(1, (32'd1 << w) - 1);
                end
            endcase
            case ($urandom_range(0, 7))
                0:       md = 32'hFFFF_FFFF;
                1:       md = 32'd2;
                2:       md = $urandom_range(2, 255);
                default:
                begin
                    md = $urandom() >> $urandom_range(0, 24);
                    if (md < 2)
                        md = 2 + $urandom_range(0, 5);
                end
            endcase
            set_key(ex, md);
            for (int i = 0; i < WORDS_PER_KEY; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       b = '0;
                    1:       b = md - 1;
                    2:       b = $urandom_range(0, md - 1);
                    3:       b = md + $urandom_range(0, 3);
                    default: b = $urandom();
                endcase
                send_word(b, 1'($urandom_range(0, 1)),
                          (k == 0 && i == 13) || $urandom_range(0, 39) == 0);
            end
        end

        // drain and watch for stray results
        s_tvalid <= 1'b0;
        while (powers.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (powers.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/modular_exponentiation.sv
test/modular_exponentiation_tb.sv
